### design/pfp_pkg.sv
// Shared types, constants and register codes of the primitive record field patcher.
`default_nettype none

package pfp_pkg;

  localparam int unsigned WORD_W     = 16;
  localparam int unsigned ACC_W      = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned STEP_W     = 6;

  // Primitive kinds: the low forms patch words 6 and 2, the high forms words 10 and 6.
  localparam logic [WORD_W-1:0] KIND_09  = 16'h0009;
  localparam logic [WORD_W-1:0] KIND_0D  = 16'h000D;
  localparam logic [WORD_W-1:0] KIND_11  = 16'h0011;
  localparam logic [WORD_W-1:0] KIND_15  = 16'h0015;
  localparam logic [WORD_W-1:0] KIND_209 = 16'h0209;
  localparam logic [WORD_W-1:0] KIND_20D = 16'h020D;
  localparam logic [WORD_W-1:0] KIND_211 = 16'h0211;
  localparam logic [WORD_W-1:0] KIND_215 = 16'h0215;

  // Record size steps added to the running total.
  localparam logic [STEP_W-1:0] STEP_SMALL = 6'h20;
  localparam logic [STEP_W-1:0] STEP_MID   = 6'h28;
  localparam logic [STEP_W-1:0] STEP_LARGE = 6'h34;

  // Word adjustment constants.
  localparam logic [WORD_W-1:0] A_ADJ_BASE   = 16'h000A;
  localparam logic [WORD_W-1:0] A_FLAG_CLEAR = 16'hFF7F;
  localparam logic [WORD_W-1:0] B_ADJ_BASE   = 16'h3BD8;
  localparam logic [WORD_W-1:0] B_LOW_MASK   = 16'h003F;
  localparam logic [6:0]        B_LOW_BIAS   = 7'h10;

  // Reset value of the kind register.
  localparam logic [WORD_W-1:0] KIND_RESET = KIND_09;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PASS_MODE   = 3'd0,
    CFG_KIND_CODE   = 3'd1,
    CFG_TRACK_MAX   = 3'd2,
    CFG_START_BEST  = 3'd3,
    CFG_START_TOTAL = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0]              pass_mode;
    logic [WORD_W-1:0]       kind_code;
    logic                    track_max;
    logic signed [ACC_W-1:0] start_best;
    logic signed [ACC_W-1:0] start_total;
  } cfg_state_t;

  typedef struct packed {
    logic              first_record;
    logic [WORD_W-1:0] word_at_2;
    logic [WORD_W-1:0] word_at_6;
    logic [WORD_W-1:0] word_at_10;
    logic [WORD_W-1:0] word_at_12;
    logic [WORD_W-1:0] word_at_14;
    logic [WORD_W-1:0] word_at_16;
    logic [WORD_W-1:0] word_at_18;
    logic [WORD_W-1:0] word_at_20;
    logic [WORD_W-1:0] word_at_24;
    logic [WORD_W-1:0] word_at_28;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0]       new_word_at_2;
    logic [WORD_W-1:0]       new_word_at_6;
    logic [WORD_W-1:0]       new_word_at_10;
    logic signed [ACC_W-1:0] running_max;
    logic signed [ACC_W-1:0] running_total;
    logic                    active;
  } out_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] new_word_at_2;
    logic [WORD_W-1:0] new_word_at_6;
    logic [WORD_W-1:0] new_word_at_10;
  } patch_words_t;

  // Control from the patch logic to the accumulators.
  typedef struct packed {
    logic              active;
    logic [STEP_W-1:0] step;
    logic [WORD_W-1:0] idx_max;
  } acc_ctl_t;

endpackage

`default_nettype wire

### design/pfp_in_if.sv
// Input record channel of the primitive record field patcher.
`default_nettype none

interface pfp_in_if;
  logic              valid;
  logic              ready;
  pfp_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### design/pfp_out_if.sv
// Result channel of the primitive record field patcher.
`default_nettype none

interface pfp_out_if;
  logic               valid;
  logic               ready;
  pfp_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### design/pfp_cfg_if.sv
// Configuration write channel of the primitive record field patcher.
`default_nettype none

interface pfp_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [pfp_pkg::CFG_IDX_W-1:0]      index;
  logic [pfp_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### design/pfp_cfg_regs.sv
// Configuration register file of the primitive record field patcher.
`default_nettype none

module pfp_cfg_regs (
  input  wire logic           clk,
  input  wire logic           rst_n,
  pfp_cfg_if.sink             cfg_ch,
  output pfp_pkg::cfg_state_t cfg
);

  pfp_pkg::cfg_state_t cfg_r;
  pfp_pkg::cfg_state_t cfg_nxt;

  // Writes are always taken.
  assign cfg_ch.ready = 1'b1;

  // Decode the register index of a write transaction.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        pfp_pkg::CFG_PASS_MODE:   cfg_nxt.pass_mode   = cfg_ch.data[1:0];
        pfp_pkg::CFG_KIND_CODE:   cfg_nxt.kind_code   = cfg_ch.data[pfp_pkg::WORD_W-1:0];
        pfp_pkg::CFG_TRACK_MAX:   cfg_nxt.track_max   = cfg_ch.data[0];
        pfp_pkg::CFG_START_BEST:  cfg_nxt.start_best  = $signed(cfg_ch.data);
        pfp_pkg::CFG_START_TOTAL: cfg_nxt.start_total = $signed(cfg_ch.data);
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pass_mode   <= 2'd0;
      cfg_r.kind_code   <= pfp_pkg::KIND_RESET;
      cfg_r.track_max   <= 1'b0;
      cfg_r.start_best  <= '0;
      cfg_r.start_total <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

### design/pfp_patch.sv
// Kind decode, word patching and index word maximum for one record.
`default_nettype none

module pfp_patch (
  input  wire pfp_pkg::cfg_state_t cfg,
  input  wire pfp_pkg::in_item_t   item,
  output pfp_pkg::patch_words_t    words,
  output pfp_pkg::acc_ctl_t        ctl
);

  logic                            known;
  logic                            high_form;
  logic [pfp_pkg::STEP_W-1:0]      step;
  logic [pfp_pkg::WORD_W-1:0]      iw0, iw1, iw2, iw3;
  logic [pfp_pkg::WORD_W-1:0]      m01, m23;
  logic                            active;
  logic [pfp_pkg::WORD_W-1:0]      va, vb;
  logic [1:0]                      flag;
  logic [pfp_pkg::WORD_W-1:0]      na_raw, na;
  logic [pfp_pkg::WORD_W-1:0]      sum;
  logic [6:0]                      b_low;
  logic [pfp_pkg::WORD_W-1:0]      nb;
  logic                            b_patch;

  // Kind decode: word form, size step and the index words.
  always_comb begin
    known     = 1'b1;
    high_form = 1'b0;
    step      = '0;
    iw0       = '0;
    iw1       = '0;
    iw2       = '0;
    iw3       = '0;
    unique case (cfg.kind_code)
      pfp_pkg::KIND_09: begin
        step = pfp_pkg::STEP_SMALL;
        iw0  = item.word_at_12;
      end
      pfp_pkg::KIND_209: begin
        high_form = 1'b1;
        step      = pfp_pkg::STEP_SMALL;
        iw0       = item.word_at_16;
      end
      pfp_pkg::KIND_0D: begin
        step = pfp_pkg::STEP_MID;
        iw0  = item.word_at_12;
        iw1  = item.word_at_16;
        iw2  = item.word_at_20;
      end
      pfp_pkg::KIND_20D: begin
        high_form = 1'b1;
        step      = pfp_pkg::STEP_MID;
        iw0       = item.word_at_16;
        iw1       = item.word_at_20;
        iw2       = item.word_at_24;
      end
      pfp_pkg::KIND_11: begin
        step = pfp_pkg::STEP_MID;
        iw0  = item.word_at_14;
      end
      pfp_pkg::KIND_211: begin
        high_form = 1'b1;
        step      = pfp_pkg::STEP_MID;
        iw0       = item.word_at_18;
      end
      pfp_pkg::KIND_15: begin
        step = pfp_pkg::STEP_LARGE;
        iw0  = item.word_at_10;
        iw1  = item.word_at_16;
        iw2  = item.word_at_20;
        iw3  = item.word_at_24;
      end
      pfp_pkg::KIND_215: begin
        high_form = 1'b1;
        step      = pfp_pkg::STEP_LARGE;
        iw0       = item.word_at_14;
        iw1       = item.word_at_20;
        iw2       = item.word_at_24;
        iw3       = item.word_at_28;
      end
      default: known = 1'b0;
    endcase
  end

  // Modes 2 and 3 disable patching.
  assign active = known && !cfg.pass_mode[1];

  // Word A: add 4*mode-10, clear bit 7 when the flag is 3.
  assign va     = high_form ? item.word_at_10 : item.word_at_6;
  assign vb     = high_form ? item.word_at_6  : item.word_at_2;
  assign flag   = va[8:7];
  assign na_raw = va + {12'd0, cfg.pass_mode, 2'd0} - pfp_pkg::A_ADJ_BASE;
  assign na     = (flag == 2'b11) ? (na_raw & pfp_pkg::A_FLAG_CLEAR) : na_raw;

  // Word B: add 16*mode plus the base; a large old B keeps only its low fields.
  assign b_patch = !flag[1];
  assign sum     = vb + {10'd0, cfg.pass_mode, 4'd0} + pfp_pkg::B_ADJ_BASE;
  assign b_low   = 7'(sum & pfp_pkg::B_LOW_MASK) + pfp_pkg::B_LOW_BIAS;
  assign nb      = (vb[15:10] != 6'd0) ? ({9'd0, b_low} | {6'd0, vb[9:6], 6'd0}) : sum;

  // Select the patched words.
  always_comb begin
    words.new_word_at_2  = item.word_at_2;
    words.new_word_at_6  = item.word_at_6;
    words.new_word_at_10 = item.word_at_10;
    if (active) begin
      if (high_form) begin
        words.new_word_at_10 = na;
        if (b_patch) begin
          words.new_word_at_6 = nb;
        end
      end else begin
        words.new_word_at_6 = na;
        if (b_patch) begin
          words.new_word_at_2 = nb;
        end
      end
    end
  end

  // Unsigned maximum of the index words; unused slots are zero and never win.
  assign m01 = (iw0 > iw1) ? iw0 : iw1;
  assign m23 = (iw2 > iw3) ? iw2 : iw3;

  assign ctl.active  = active;
  assign ctl.step    = step;
  assign ctl.idx_max = (m01 > m23) ? m01 : m23;

endmodule

`default_nettype wire

### design/pfp_accum.sv
// Running maximum and running size total carried from record to record.
`default_nettype none

module pfp_accum (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                advance,
  input  wire logic                                first,
  input  wire pfp_pkg::cfg_state_t                 cfg,
  input  wire pfp_pkg::acc_ctl_t                   ctl,
  output logic signed [pfp_pkg::ACC_W-1:0]         max_nxt,
  output logic signed [pfp_pkg::ACC_W-1:0]         total_nxt
);

  logic signed [pfp_pkg::ACC_W-1:0] max_acc_r;
  logic signed [pfp_pkg::ACC_W-1:0] total_acc_r;
  logic signed [pfp_pkg::ACC_W-1:0] base_max;
  logic signed [pfp_pkg::ACC_W-1:0] base_total;
  logic signed [pfp_pkg::ACC_W-1:0] cand;

  // A first record reloads both accumulators before it is handled.
  assign base_max   = first ? cfg.start_best  : max_acc_r;
  assign base_total = first ? cfg.start_total : total_acc_r;

  // Index words are nonnegative when taken as 32-bit signed values.
  assign cand = $signed({16'd0, ctl.idx_max});

  assign max_nxt   = (ctl.active && cfg.track_max && (base_max < cand)) ? cand : base_max;
  assign total_nxt = ctl.active ? (base_total + $signed({26'd0, ctl.step})) : base_total;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_acc_r   <= '0;
      total_acc_r <= '0;
    end else if (advance) begin
      max_acc_r   <= max_nxt;
      total_acc_r <= total_nxt;
    end
  end

  // Accumulators change only when a record moves to the result register.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(max_acc_r) && $stable(total_acc_r))
    else $error("accumulators changed without a record");

  // A passed-through record that is not a first record leaves the total alone.
  a_idle_total: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !first && !ctl.active |=> total_acc_r == $past(total_acc_r))
    else $error("total moved on an inactive record");

  // The running maximum never falls between reloads.
  a_max_mono: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !first |=> max_acc_r >= $past(max_acc_r))
    else $error("running maximum decreased");

endmodule

`default_nettype wire

### design/primitive_record_field_patcher.sv
// Top level of the primitive record field patcher: input register, patch logic, result register.
// A record in the input register moves to the result register once that register is free.
// Throughput: one record per cycle unless out_ch stalls; max and total update once per record.
// The input register is refilled whenever its record moves on, so stalls cost no bubbles.
// Reset (rst_n low at a clock edge) empties both registers, clears both accumulators,
// and sets the mode to 0, the kind to 9, tracking off and both start values to zero.
`default_nettype none

module primitive_record_field_patcher (
  input  wire logic clk,
  input  wire logic rst_n,
  pfp_in_if.sink    in_ch,
  pfp_out_if.source out_ch,
  pfp_cfg_if.sink   cfg_ch
);

  pfp_pkg::cfg_state_t   cfg;
  pfp_pkg::patch_words_t words;
  pfp_pkg::acc_ctl_t     ctl;

  logic                  s1_valid_r;
  logic                  s1_valid_nxt;
  pfp_pkg::in_item_t     s1_data_r;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  pfp_pkg::out_item_t    out_data_r;
  logic                  s2_free;
  logic                  advance;
  logic                  in_take;

  logic signed [pfp_pkg::ACC_W-1:0] max_nxt;
  logic signed [pfp_pkg::ACC_W-1:0] total_nxt;

  pfp_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  pfp_patch u_patch (
    .cfg   (cfg),
    .item  (s1_data_r),
    .words (words),
    .ctl   (ctl)
  );

  pfp_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .first     (s1_data_r.first_record),
    .cfg       (cfg),
    .ctl       (ctl),
    .max_nxt   (max_nxt),
    .total_nxt (total_nxt)
  );

  // Handshake: the result register frees up when it is empty or being read.
  assign s2_free     = !out_valid_r || out_ch.ready;
  assign advance     = s1_valid_r && s2_free;
  assign in_ch.ready = !s1_valid_r || s2_free;
  assign in_take     = in_ch.valid && in_ch.ready;

  assign s1_valid_nxt  = in_take ? 1'b1 : (advance ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = advance ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_ch.payload;
    end
    if (advance) begin
      out_data_r.new_word_at_2  <= words.new_word_at_2;
      out_data_r.new_word_at_6  <= words.new_word_at_6;
      out_data_r.new_word_at_10 <= words.new_word_at_10;
      out_data_r.running_max    <= max_nxt;
      out_data_r.running_total  <= total_nxt;
      out_data_r.active         <= ctl.active;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_data_r;

  // A newly valid result must come from a filled input register.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !$past(out_valid_r) |-> $past(s1_valid_r))
    else $error("result appeared without a record in the input register");

endmodule

`default_nettype wire
